/* design/hnd_pkg.sv */
package hnd_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 4096;
    localparam int unsigned NAME_CHARS      = 8;
    localparam int unsigned CHAR_W          = 8;
    localparam int unsigned NAME_W          = NAME_CHARS * CHAR_W;
    localparam int unsigned CFG_W           = 13;
    localparam int unsigned HASH_W          = 32;
    localparam int unsigned DCNT_W          = $clog2(HASH_W + 1);
    localparam int unsigned OUT_IDX_W       = 12;
    localparam int unsigned CHAR_IDX_W      = $clog2(NAME_CHARS);
    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [NAME_W-1:0] name_bytes;
    } dir_in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] entry_index;
    } dir_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hash_step;
        logic div_start;
        logic div_step;
        logic clr_start;
        logic clr_step;
        logic head_rd;
        logic ins_wr;
        logic walk_load;
        logic node_rd;
        logic walk_next;
        logic cnt_clear;
        logic res_clear;
        logic res_ins;
        logic res_found;
        logic res_miss;
        logic res_full;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_done;
        logic div_done;
        logic clr_done;
        logic full;
        logic cur_valid;
        logic match;
    } dp_sts_t;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Zero every byte after the first NUL.
    function automatic logic [NAME_W-1:0] canon(input logic [NAME_W-1:0] w);
        logic [NAME_W-1:0] r;
        logic              alive;
        r     = '0;
        alive = 1'b1;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            if (w[k*CHAR_W +: CHAR_W] == '0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                r[k*CHAR_W +: CHAR_W] = w[k*CHAR_W +: CHAR_W];
            end
        end
        return r;
    endfunction

    function automatic logic [NAME_W-1:0] upper_name(input logic [NAME_W-1:0] w);
        logic [NAME_W-1:0] r;
        r = '0;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            r[k*CHAR_W +: CHAR_W] = to_upper(w[k*CHAR_W +: CHAR_W]);
        end
        return r;
    endfunction

endpackage

/* design/hnd_ram.sv */
module hnd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/hnd_datapath.sv */
module hnd_datapath
    import hnd_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           ctl_cmd,
    output dp_sts_t           ctl_sts,
    input  logic [NAME_W-1:0] name_in,
    input  logic [CFG_W-1:0]  entry_count,
    output dir_out_t          result
);

    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned LW = IW + 1;

    logic [NAME_W-1:0]     name_reg;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [CHAR_IDX_W-1:0] k_reg, k_next;
    logic                  hfin_reg, hfin_next;
    logic [HASH_W-1:0]     dvd_reg;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic [CW-1:0]         cnt_reg;
    logic [IW-1:0]         clr_addr_reg;
    logic                  cur_valid_reg;
    logic [IW-1:0]         cur_idx_reg;
    dir_out_t              res_reg;

    logic [CW-1:0]     modv;
    logic [CHAR_W-1:0] ch, uch;
    logic [CW:0]       trial;

    logic              head_we;
    logic [IW-1:0]     head_waddr;
    logic [LW-1:0]     head_wdata, head_q, link_q;
    logic [NAME_W-1:0] name_q;

    // The modulus in use is the configured count held to 1..MAX_ENTRIES.
    always_comb
    begin
        if (entry_count == '0)
        begin
            modv = CW'(1);
        end
        else if (32'(entry_count) > 32'(MAX_ENTRIES))
        begin
            modv = CW'(MAX_ENTRIES);
        end
        else
        begin
            modv = CW'(entry_count);
        end
    end

    assign ch  = name_reg[k_reg*CHAR_W +: CHAR_W];
    assign uch = to_upper(ch);

    // One character of the hash per cycle.
    always_comb
    begin
        hash_next = hash_reg;
        k_next    = k_reg;
        hfin_next = hfin_reg;
        if (ctl_cmd.load)
        begin
            hash_next = {{(HASH_W-CHAR_W){1'b0}}, to_upper(name_in[CHAR_W-1:0])};
            k_next    = CHAR_IDX_W'(1);
            hfin_next = 1'b0;
        end
        else if (ctl_cmd.hash_step)
        begin
            if (k_reg == CHAR_IDX_W'(NAME_CHARS - 1))
            begin
                hash_next = (hash_reg << 1) + {{(HASH_W-CHAR_W){1'b0}}, uch};
                hfin_next = 1'b1;
            end
            else if (ch == '0)
            begin
                hfin_next = 1'b1;
            end
            else
            begin
                if (k_reg == CHAR_IDX_W'(1))
                begin
                    hash_next = hash_reg + (hash_reg << 1)
                                + {{(HASH_W-CHAR_W){1'b0}}, uch};
                end
                else
                begin
                    hash_next = (hash_reg << 1) + {{(HASH_W-CHAR_W){1'b0}}, uch};
                end
                k_next = k_reg + CHAR_IDX_W'(1);
            end
        end
    end

    // Restoring remainder, one dividend bit per cycle.
    assign trial = {rem_reg, dvd_reg[HASH_W-1]};
    always_comb
    begin
        if (trial >= {1'b0, modv})
        begin
            rem_next = CW'(trial - {1'b0, modv});
        end
        else
        begin
            rem_next = trial[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            hfin_reg      <= 1'b0;
            dcnt_reg      <= '0;
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg    <= k_next;
            hfin_reg <= hfin_next;
            if (ctl_cmd.div_start)
            begin
                dcnt_reg <= DCNT_W'(HASH_W);
            end
            else if (ctl_cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            if (ctl_cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (ctl_cmd.ins_wr)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (ctl_cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (ctl_cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + IW'(1);
            end
            if (ctl_cmd.walk_load)
            begin
                cur_valid_reg <= head_q[LW-1];
            end
            else if (ctl_cmd.walk_next)
            begin
                cur_valid_reg <= link_q[LW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.load)
        begin
            name_reg <= canon(name_in);
        end
        hash_reg <= hash_next;
        if (ctl_cmd.div_start)
        begin
            dvd_reg <= hash_reg;
            rem_reg <= '0;
        end
        else if (ctl_cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
        if (ctl_cmd.walk_load)
        begin
            cur_idx_reg <= head_q[IW-1:0];
        end
        else if (ctl_cmd.walk_next)
        begin
            cur_idx_reg <= link_q[IW-1:0];
        end
        if (ctl_cmd.res_clear)
        begin
            res_reg <= '{status: ST_OK, entry_index: '0};
        end
        else if (ctl_cmd.res_ins)
        begin
            res_reg <= '{status: ST_OK, entry_index: OUT_IDX_W'(cnt_reg)};
        end
        else if (ctl_cmd.res_found)
        begin
            res_reg <= '{status: ST_OK, entry_index: OUT_IDX_W'(cur_idx_reg)};
        end
        else if (ctl_cmd.res_miss)
        begin
            res_reg <= '{status: ST_NOT_FOUND, entry_index: '0};
        end
        else if (ctl_cmd.res_full)
        begin
            res_reg <= '{status: ST_FULL, entry_index: '0};
        end
    end

    // The head store is swept to empty after reset or on a clear, or written on an insert.
    always_comb
    begin
        head_we    = ctl_cmd.clr_step | ctl_cmd.ins_wr;
        head_waddr = rem_reg[IW-1:0];
        head_wdata = {1'b1, cnt_reg[IW-1:0]};
        if (ctl_cmd.clr_step)
        begin
            head_waddr = clr_addr_reg;
            head_wdata = '0;
        end
    end

    hnd_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (ctl_cmd.head_rd),
        .raddr (rem_reg[IW-1:0]),
        .rdata (head_q)
    );

    hnd_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_links (
        .clk   (clk),
        .we    (ctl_cmd.ins_wr),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (head_q),
        .re    (ctl_cmd.node_rd),
        .raddr (cur_idx_reg),
        .rdata (link_q)
    );

    hnd_ram #(.WIDTH(NAME_W), .DEPTH(MAX_ENTRIES)) u_names (
        .clk   (clk),
        .we    (ctl_cmd.ins_wr),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (name_reg),
        .re    (ctl_cmd.node_rd),
        .raddr (cur_idx_reg),
        .rdata (name_q)
    );

    assign ctl_sts.hash_done = hfin_reg;
    assign ctl_sts.div_done  = (dcnt_reg == '0);
    assign ctl_sts.clr_done  = (clr_addr_reg == IW'(MAX_ENTRIES - 1));
    assign ctl_sts.full      = (cnt_reg >= modv);
    assign ctl_sts.cur_valid = cur_valid_reg;
    // Both names are stored with zeros after the NUL, so a full compare suffices.
    assign ctl_sts.match     = (upper_name(name_q) == upper_name(name_reg));

    assign result = res_reg;

endmodule

/* design/hnd_ctrl.sv */
module hnd_ctrl
    import hnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] op,
    input  dp_sts_t    ctl_sts,
    output dp_cmd_t    ctl_cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CLR   = 8'b0000_0100,
        S_HASH  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_HDATA = 8'b0010_0000,
        S_NODE  = 8'b0100_0000,
        S_CMP   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ctl_cmd    = '0;
        case (state_reg)
            S_INIT:
            begin
                ctl_cmd.clr_step = 1'b1;
                if (ctl_sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = op;
                    case (op)
                        OP_CLEAR:
                        begin
                            ctl_cmd.cnt_clear = 1'b1;
                            ctl_cmd.clr_start = 1'b1;
                            state_next        = S_CLR;
                        end
                        OP_INSERT:
                        begin
                            if (ctl_sts.full)
                            begin
                                ctl_cmd.res_full = 1'b1;
                            end
                            else
                            begin
                                ctl_cmd.load = 1'b1;
                                state_next   = S_HASH;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            ctl_cmd.load = 1'b1;
                            state_next   = S_HASH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                ctl_cmd.clr_step = 1'b1;
                if (ctl_sts.clr_done)
                begin
                    ctl_cmd.res_clear = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_HASH:
            begin
                if (ctl_sts.hash_done)
                begin
                    ctl_cmd.div_start = 1'b1;
                    state_next        = S_DIV;
                end
                else
                begin
                    ctl_cmd.hash_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (ctl_sts.div_done)
                begin
                    ctl_cmd.head_rd = 1'b1;
                    state_next      = S_HDATA;
                end
                else
                begin
                    ctl_cmd.div_step = 1'b1;
                end
            end
            S_HDATA:
            begin
                if (op_reg == OP_INSERT)
                begin
                    ctl_cmd.ins_wr  = 1'b1;
                    ctl_cmd.res_ins = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ctl_cmd.walk_load = 1'b1;
                    state_next        = S_NODE;
                end
            end
            S_NODE:
            begin
                if (ctl_sts.cur_valid)
                begin
                    ctl_cmd.node_rd = 1'b1;
                    state_next      = S_CMP;
                end
                else
                begin
                    ctl_cmd.res_miss = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (ctl_sts.match)
                begin
                    ctl_cmd.res_found = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    ctl_cmd.walk_next = 1'b1;
                    state_next        = S_NODE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = ctl_cmd.res_clear | ctl_cmd.res_ins | ctl_cmd.res_found
                     | ctl_cmd.res_miss | ctl_cmd.res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            op_reg    <= OP_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

/* design/hashed_name_directory.sv */
// Channel   Ports                                  Transfer
// -------   -------------------------------------  -------------------------------
// request   start, busy, request (op, name_bytes)  edge with start high, busy low
// result    done, result (status, entry_index)     every cycle with done high
// config    psel, penable, pwrite, paddr, pwdata,  edge with psel, penable, pwrite
//           prdata, pready                         and pready high
//
// After reset the chain-head memory is swept to empty with busy high. A clear
// runs the same sweep before its result. Insert and lookup hash one character
// a cycle, then take the remainder one bit a cycle, then read the chain head:
// an insert then writes the new entry and its result, and a lookup walks the
// chain, comparing the name of each entry it visits, until a match or its end.
// A full insert answers the next cycle.
// done is a one-cycle strobe; the receiver cannot stall it.
module hashed_name_directory
    import hnd_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  dir_in_t               request,
    output logic                  done,
    output dir_out_t              result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] entry_count_reg;
    logic             cfg_sel;
    dp_cmd_t          ctl_cmd;
    dp_sts_t          ctl_sts;

    // The only register is selected by any address with its top bit clear (0 to 3).
    assign cfg_sel = (paddr[APB_ADDR_W-1] == 1'b0);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CFG_W'(1);
        end
        else if (psel && penable && pwrite && cfg_sel)
        begin
            entry_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(APB_DATA_W-CFG_W){1'b0}}, entry_count_reg} : '0;

    hnd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op      (request.op),
        .ctl_sts (ctl_sts),
        .ctl_cmd (ctl_cmd),
        .busy    (busy),
        .done    (done)
    );

    hnd_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_cmd     (ctl_cmd),
        .ctl_sts     (ctl_sts),
        .name_in     (request.name_bytes),
        .entry_count (entry_count_reg),
        .result      (result)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import hnd_pkg::*;

    localparam int unsigned TABLE_SIZE = MAX_ENTRIES_DEF;
    localparam longint      CYCLE_LIMIT = 3_000_000;
    localparam int          PHASES = 20;
    localparam int          ITEMS_PER_PHASE = 70;

    typedef struct {
        bit          cfg;
        logic [1:0]  op;
        logic [63:0] name;
        bit          typed;
        logic [1:0]  st;
        logic [11:0] idx;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    dir_in_t               request;
    logic                  done;
    dir_out_t              result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hashed_name_directory dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted directory contents.
    logic [63:0] dir_names [TABLE_SIZE];
    logic [12:0] dir_links [TABLE_SIZE];
    bit          dir_link_ok [TABLE_SIZE];
    logic [12:0] dir_heads [TABLE_SIZE];
    bit          dir_head_ok [TABLE_SIZE];
    int unsigned dir_fill;
    logic [12:0] dir_size;

    dir_out_t    pending_results[$];
    int          n_errors;
    longint      cycle_count;
    int          n_insert, n_hit, n_miss, n_full, n_clear, n_results;
    bit          calm;
    logic [63:0] name_pool[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("hashed_name_directory: mismatch");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("[%0t] error: %s", $realtime, what);
    endtask

    function automatic logic [7:0] up_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic [63:0] trim_name(input logic [63:0] w);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (w[k*8 +: 8] == 8'h00)
            begin
                break;
            end
            r[k*8 +: 8] = w[k*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [31:0] name_hash(input logic [63:0] w);
        logic [31:0] h;
        h = 32'(up_char(w[7:0]));
        for (int k = 1; k <= 6; k++)
        begin
            if (w[k*8 +: 8] == 8'h00)
            begin
                return h;
            end
            h = h * ((k == 1) ? 32'd3 : 32'd2) + 32'(up_char(w[k*8 +: 8]));
        end
        return h * 32'd2 + 32'(up_char(w[63:56]));
    endfunction

    function automatic bit same_name(input logic [63:0] a, input logic [63:0] b);
        for (int k = 0; k < 8; k++)
        begin
            if (up_char(a[k*8 +: 8]) != up_char(b[k*8 +: 8]))
            begin
                return 1'b0;
            end
            if (a[k*8 +: 8] == 8'h00)
            begin
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic int unsigned chain_modulus();
        if (dir_size == 0)
        begin
            return 1;
        end
        if (dir_size > TABLE_SIZE)
        begin
            return TABLE_SIZE;
        end
        return dir_size;
    endfunction

    // Applies one command to the predicted directory; the unused op yields nothing.
    task automatic directory_apply(input dir_in_t req, output bit has, output dir_out_t exp);
        logic [63:0] nm;
        int unsigned m, j, i, steps;
        bit          ok;
        nm  = trim_name(req.name_bytes);
        m   = chain_modulus();
        has = 1'b1;
        exp = '0;
        if (req.op == OP_CLEAR)
        begin
            foreach (dir_head_ok[k])
            begin
                dir_head_ok[k] = 1'b0;
            end
            dir_fill = 0;
            n_clear++;
        end
        else if (req.op == OP_INSERT)
        begin
            if (dir_fill >= m)
            begin
                exp.status = ST_FULL;
                n_full++;
            end
            else
            begin
                j = name_hash(nm) % m;
                dir_names[dir_fill]   = nm;
                dir_links[dir_fill]   = dir_heads[j];
                dir_link_ok[dir_fill] = dir_head_ok[j];
                dir_heads[j]          = 13'(dir_fill);
                dir_head_ok[j]        = 1'b1;
                exp.entry_index       = 12'(dir_fill);
                dir_fill++;
                n_insert++;
            end
        end
        else if (req.op == OP_LOOKUP)
        begin
            j     = name_hash(nm) % m;
            ok    = dir_head_ok[j];
            i     = dir_heads[j];
            steps = 0;
            exp.status = ST_NOT_FOUND;
            while (ok && i < TABLE_SIZE && steps < TABLE_SIZE)
            begin
                if (same_name(dir_names[i], nm))
                begin
                    exp.status      = ST_OK;
                    exp.entry_index = 12'(i);
                    break;
                end
                ok = dir_link_ok[i];
                i  = dir_links[i];
                steps++;
            end
            if (exp.status == ST_OK)
            begin
                n_hit++;
            end
            else
            begin
                n_miss++;
            end
        end
        else
        begin
            has = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        dir_out_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d index=%0d",
                                 result.status, result.entry_index));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    report($sformatf("status %0d, expected %0d", result.status, want.status));
                end
                if (result.entry_index !== want.entry_index)
                begin
                    report($sformatf("entry_index %0d, expected %0d",
                                     result.entry_index, want.entry_index));
                end
            end
        end
    end

    // Ends right after the transfer edge so the caller owns the next falling edge.
    task automatic send(input logic [1:0] op, input logic [63:0] name, input bit typed,
                        input dir_out_t typed_exp);
        dir_in_t  req;
        bit       has;
        dir_out_t exp;
        req.op         = op;
        req.name_bytes = name;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        directory_apply(req, has, exp);
        if (has)
        begin
            pending_results.push_back(typed ? typed_exp : exp);
        end
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 33)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= dir_in_t'({$urandom, $urandom, 2'($urandom)});
            repeat ($urandom_range(6)) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0 || busy);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_size(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        dir_size = value[12:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
    endtask

    function automatic logic [63:0] random_name();
        logic [63:0] w;
        int          len;
        len = ($urandom_range(9) == 0) ? 8 : $urandom_range(8);
        w   = {$urandom, $urandom};
        for (int k = 0; k < 8; k++)
        begin
            if (k < len)
            begin
                if ($urandom_range(3) != 0)
                begin
                    w[k*8 +: 8] = 8'($urandom_range(25) + ($urandom_range(1) ? 8'h41 : 8'h61));
                end
                else
                begin
                    w[k*8 +: 8] = 8'($urandom_range(255, 1));
                end
            end
            else if (k == len)
            begin
                w[k*8 +: 8] = 8'h00;
            end
        end
        return w;
    endfunction

    // Same name as far as the block is concerned: letters flip case, tail changes.
    function automatic logic [63:0] alias_name(input logic [63:0] w);
        logic [63:0] r;
        bit          dead;
        r    = w;
        dead = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (dead)
            begin
                r[k*8 +: 8] = 8'($urandom);
            end
            else if (w[k*8 +: 8] == 8'h00)
            begin
                dead = 1'b1;
            end
            else if (up_char(w[k*8 +: 8]) >= 8'h41 && up_char(w[k*8 +: 8]) <= 8'h5A
                     && $urandom_range(1))
            begin
                r[k*8 +: 8] = w[k*8 +: 8] ^ 8'h20;
            end
        end
        return r;
    endfunction

    dir_row_t opening[$];

    task automatic add_row(input bit cfg, input logic [1:0] op, input logic [63:0] name,
                           input bit typed, input logic [1:0] st, input logic [11:0] idx);
        dir_row_t r;
        r = '{cfg, op, name, typed, st, idx};
        opening.push_back(r);
    endtask

    initial
    begin
        dir_out_t    ex;
        logic [1:0]  op;
        logic [63:0] nm;
        int          roll;
        logic [31:0] sizes[$];

        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        n_errors    = 0;
        cycle_count = 0;
        dir_fill    = 0;
        dir_size    = 13'd1;
        calm        = 1'b0;
        foreach (dir_head_ok[k])
        begin
            dir_head_ok[k] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Size 1 after reset: one entry fits, a second reports full.
        add_row(0, OP_LOOKUP, 64'h0000_0000_0043_4241, 1, ST_NOT_FOUND, 0);
        add_row(0, OP_INSERT, 64'h0000_0000_0063_6261, 1, ST_OK, 0);
        add_row(0, OP_INSERT, 64'h0000_0000_0000_0078, 1, ST_FULL, 0);
        add_row(0, OP_LOOKUP, 64'h7777_0000_0043_4241, 0, 0, 0);
        add_row(0, OP_UNUSED, 64'h0000_0000_0063_6261, 0, 0, 0);
        add_row(0, OP_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 0);
        add_row(0, OP_LOOKUP, 64'h0000_0000_0063_6261, 1, ST_NOT_FOUND, 0);
        // Oversized count saturates to the full table.
        add_row(1, 0, 64'hFFFF_FFFF_FFFF_1FFF, 0, 0, 0);
        add_row(0, OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 0);
        add_row(0, OP_INSERT, 64'h0000_0000_0000_0000, 1, ST_OK, 1);
        add_row(0, OP_INSERT, 64'h5A5A_1234_0000_6261, 1, ST_OK, 2);
        add_row(0, OP_LOOKUP, 64'h0101_0101_0000_4241, 0, 0, 0);
        add_row(0, OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        add_row(0, OP_LOOKUP, 64'h1122_3344_5566_7700, 0, 0, 0);
        add_row(0, OP_INSERT, 64'h0000_0000_0000_4241, 1, ST_OK, 3);
        add_row(0, OP_LOOKUP, 64'h0000_0000_0000_4261, 0, 0, 0);
        add_row(0, OP_INSERT, 64'h7A79_7877_6463_6261, 1, ST_OK, 4);
        add_row(0, OP_LOOKUP, 64'h5A59_5857_4443_4241, 0, 0, 0);
        // Zero count saturates to one; the table already holds more.
        add_row(1, 0, 64'h0000_0000_FFFF_E000, 0, 0, 0);
        add_row(0, OP_INSERT, 64'h0000_0000_0000_0071, 1, ST_FULL, 0);
        add_row(0, OP_LOOKUP, 64'h0000_0000_0000_6261, 0, 0, 0);
        add_row(1, 0, 64'h0000_0000_0000_0003, 0, 0, 0);
        add_row(0, OP_LOOKUP, 64'h0000_0000_0000_0000, 0, 0, 0);
        add_row(0, OP_CLEAR,  64'h0000_0000_0000_0000, 1, ST_OK, 0);
        add_row(0, OP_INSERT, 64'h0000_0000_0000_0061, 1, ST_OK, 0);

        foreach (opening[r])
        begin
            if (opening[r].cfg)
            begin
                wait_idle();
                write_size(opening[r].name[31:0]);
            end
            else
            begin
                ex.status      = opening[r].st;
                ex.entry_index = opening[r].idx;
                send(opening[r].op, opening[r].name, opening[r].typed, ex);
                maybe_idle();
            end
        end

        sizes = '{32'd1, 32'd2, 32'd3, 32'd7, 32'd16, 32'd64, 32'd0, 32'd8191, 32'd4096,
                  32'd5, 32'd31, 32'd12, 32'd100, 32'd4095, 32'd9, 32'd48, 32'd2, 32'd24,
                  32'd13, 32'd40};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph == 5 || ph == 14);
            wait_idle();
            write_size({19'($urandom_range(2**19 - 1)), sizes[ph][12:0]});
            if (ph % 2 == 0)
            begin
                send(OP_CLEAR, {$urandom, $urandom}, 0, ex);
                name_pool.delete();
            end
            for (int it = 0; it < ITEMS_PER_PHASE; it++)
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                begin
                    op = OP_INSERT;
                end
                else if (roll < 95)
                begin
                    op = OP_LOOKUP;
                end
                else if (roll < 98)
                begin
                    op = OP_UNUSED;
                end
                else
                begin
                    op = OP_CLEAR;
                end
                if (name_pool.size() > 0 && $urandom_range(99) < 65)
                begin
                    nm = alias_name(name_pool[$urandom_range(name_pool.size() - 1)]);
                end
                else
                begin
                    nm = random_name();
                end
                if (op == OP_INSERT)
                begin
                    name_pool.push_back(nm);
                end
                send(op, nm, 0, ex);
                maybe_idle();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        $display("covered %0d inserts, %0d full, %0d lookups found, %0d missed, %0d clears",
                 n_insert, n_full, n_hit, n_miss, n_clear);
        $display("%0d results checked, %0d errors, %0d cycles",
                 n_results, n_errors, cycle_count);
        if (n_errors == 0)
        begin
            $display("hashed_name_directory: match");
        end
        else
        begin
            $display("hashed_name_directory: mismatch");
        end
        $finish;
    end

endmodule
